### rtl/ca5fpc_pkg.sv
// Shared types and constants for the five-neighborhood automaton cycle checker.
// Used by the top level and by the port checker; no dependencies.
`timescale 1ns / 1ps

package ca5fpc_pkg;

    localparam int RULE_W    = 32;
    localparam int CELLS_W   = 4;
    localparam int COUNT_W   = 13;
    localparam int WINDOW_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RULE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CELLS = 1'b1;

    localparam logic [CELLS_W-1:0] CELLS_RESET = 4'd12;

    typedef logic [COUNT_W-1:0] t_count;

endpackage

### rtl/ca5fpc_next_state.sv
// Next-state evaluator: applies the 32-bit rule to every five-cell window at once.
// Depends on ca5fpc_pkg for the window width.
`timescale 1ns / 1ps

module ca5fpc_next_state #(
    parameter int MAX_CELLS = 12
) (
    input  logic [MAX_CELLS-1:0]          i_state,
    input  logic [MAX_CELLS-1:0]          i_mask,
    input  logic [ca5fpc_pkg::RULE_W-1:0] i_rule,
    output logic [MAX_CELLS-1:0]          o_next
);

    logic [MAX_CELLS+3:0] widened;

    assign widened = {2'b00, i_state & i_mask, 2'b00};

    always_comb begin
        logic [ca5fpc_pkg::WINDOW_W-1:0] v_code;
        v_code = '0;
        for (int b = 0; b < MAX_CELLS; b++) begin
            v_code    = widened[b +: ca5fpc_pkg::WINDOW_W];
            o_next[b] = i_mask[b] & i_rule[v_code];
        end
    end

endmodule

### rtl/ca5fpc_visit_mem.sv
// Visit tag store and fixed point seen store, one shared write address and one read address.
// Read data is registered; no dependencies.
`timescale 1ns / 1ps

module ca5fpc_visit_mem #(
    parameter int ADDR_W = 12,
    parameter int TAG_W  = 13
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic              i_tag_we,
    input  logic [TAG_W-1:0]  i_tag_wdata,
    input  logic              i_seen_we,
    input  logic              i_seen_wdata,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [TAG_W-1:0]  o_tag_rdata,
    output logic              o_seen_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [TAG_W-1:0] r_tag_mem  [DEPTH];
    logic             r_seen_mem [DEPTH];
    logic [TAG_W-1:0] r_tag_rdata;
    logic             r_seen_rdata;

    always_ff @(posedge i_clk) begin
        if (i_tag_we) begin
            r_tag_mem[i_wr_addr] <= i_tag_wdata;
        end
        if (i_seen_we) begin
            r_seen_mem[i_wr_addr] <= i_seen_wdata;
        end
        if (i_rd_en) begin
            r_tag_rdata  <= r_tag_mem[i_rd_addr];
            r_seen_rdata <= r_seen_mem[i_rd_addr];
        end
    end

    assign o_tag_rdata  = r_tag_rdata;
    assign o_seen_rdata = r_seen_rdata;

endmodule

### rtl/ca5_fixed_point_cycle_checker_core.sv
// Top level of the automaton cycle checker: sequencer, configuration and stream ports.
// Depends on ca5fpc_pkg, ca5fpc_next_state and ca5fpc_visit_mem.
`timescale 1ns / 1ps
//
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: go, zero fill
// m_axis    out        tdata: multi_cycle_found, fixed_point_count[12:0], zero fill
// cfg       in         i_cfg_idx 0: rule_bits, 1: cell_count; i_cfg_data
//
// A run clears 2^n store entries, where n is the saturated cell count, one per cycle.
// Then for each start state it tags the state and walks its chain, with a store read and a
// check per step, ending the run early at a longer cycle; one next-state unit serves all.
// A word with go low is taken without starting a run and gives no result.
// The input is not ready during a run or while the finished result waits for a free
// output register. Reset is synchronous and active low.

module ca5_fixed_point_cycle_checker_core #(
    parameter int MAX_CELLS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ca5fpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ca5fpc_pkg::RULE_W-1:0]       i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ca5fpc_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // go, zero fill
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ca5fpc_pkg::M_TDATA_W-1:0]    m_axis_tdata    // multi, count, zero fill
);

    localparam int ADDR_W = MAX_CELLS;
    localparam int TAG_W  = MAX_CELLS + 1;
    localparam int N_W    = $clog2(MAX_CELLS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_ADV   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                        r_state, n_state;
    logic [ca5fpc_pkg::RULE_W-1:0]     r_rule;
    logic [ca5fpc_pkg::CELLS_W-1:0]    r_cells;
    logic [ADDR_W-1:0]                 r_mask, n_mask;
    logic [ADDR_W-1:0]                 r_addr, n_addr;
    logic [ADDR_W-1:0]                 r_start, n_start;
    logic [ADDR_W-1:0]                 r_cur, n_cur;
    logic [ADDR_W-1:0]                 r_nxt, n_nxt;
    ca5fpc_pkg::t_count                r_count, n_count;
    logic                              r_multi, n_multi;
    logic                              r_m_valid, n_m_valid;
    logic                              r_m_multi, n_m_multi;
    ca5fpc_pkg::t_count                r_m_count, n_m_count;

    logic [N_W-1:0]                    sat_n;
    logic [ADDR_W-1:0]                 sat_mask;
    logic [ADDR_W-1:0]                 adv_next;
    logic [TAG_W-1:0]                  cur_tag;
    logic [TAG_W-1:0]                  tag_rdata;
    logic                              seen_rdata;
    logic                              tag_we, seen_we, seen_wdata, rd_en;
    logic [TAG_W-1:0]                  tag_wdata;
    logic [ADDR_W-1:0]                 wr_addr;
    logic                              in_accept;

    always_comb begin
        if (r_cells == '0) begin
            sat_n = N_W'(1);
        end else if (32'(r_cells) > MAX_CELLS) begin
            sat_n = N_W'(MAX_CELLS);
        end else begin
            sat_n = N_W'(r_cells);
        end
        for (int i = 0; i < ADDR_W; i++) begin
            sat_mask[i] = (i < 32'(sat_n));
        end
    end

    ca5fpc_next_state #(
        .MAX_CELLS (MAX_CELLS)
    ) u_next_state (
        .i_state (r_cur),
        .i_mask  (r_mask),
        .i_rule  (r_rule),
        .o_next  (adv_next)
    );

    ca5fpc_visit_mem #(
        .ADDR_W (ADDR_W),
        .TAG_W  (TAG_W)
    ) u_visit_mem (
        .i_clk        (i_clk),
        .i_wr_addr    (wr_addr),
        .i_tag_we     (tag_we),
        .i_tag_wdata  (tag_wdata),
        .i_seen_we    (seen_we),
        .i_seen_wdata (seen_wdata),
        .i_rd_en      (rd_en),
        .i_rd_addr    (adv_next),
        .o_tag_rdata  (tag_rdata),
        .o_seen_rdata (seen_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cur_tag       = {1'b0, r_start} + TAG_W'(1);

    always_comb begin
        n_state    = r_state;
        n_mask     = r_mask;
        n_addr     = r_addr;
        n_start    = r_start;
        n_cur      = r_cur;
        n_nxt      = r_nxt;
        n_count    = r_count;
        n_multi    = r_multi;
        n_m_valid  = r_m_valid;
        n_m_multi  = r_m_multi;
        n_m_count  = r_m_count;
        tag_we     = 1'b0;
        seen_we    = 1'b0;
        seen_wdata = 1'b0;
        tag_wdata  = '0;
        wr_addr    = r_addr;
        rd_en      = 1'b0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept && s_axis_tdata[0]) begin
                    n_mask  = sat_mask;
                    n_addr  = '0;
                    n_start = '0;
                    n_count = '0;
                    n_multi = 1'b0;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                tag_we  = 1'b1;
                seen_we = 1'b1;
                wr_addr = r_addr;
                if (r_addr == r_mask) begin
                    n_state = S_START;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_START: begin
                tag_we    = 1'b1;
                wr_addr   = r_start;
                tag_wdata = cur_tag;
                n_cur     = r_start;
                n_state   = S_ADV;
            end
            S_ADV: begin
                rd_en   = 1'b1;
                n_nxt   = adv_next;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (tag_rdata != cur_tag) begin
                    tag_we    = 1'b1;
                    wr_addr   = r_nxt;
                    tag_wdata = cur_tag;
                    n_cur     = r_nxt;
                    n_state   = S_ADV;
                end else if (r_cur == r_nxt) begin
                    if (!seen_rdata) begin
                        seen_we    = 1'b1;
                        wr_addr    = r_nxt;
                        seen_wdata = 1'b1;
                        n_count    = r_count + ca5fpc_pkg::COUNT_W'(1);
                    end
                    if (r_start == r_mask) begin
                        n_state = S_OUT;
                    end else begin
                        n_start = r_start + ADDR_W'(1);
                        n_state = S_START;
                    end
                end else begin
                    n_multi = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_multi = r_multi;
                    n_m_count = r_count;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_rule    <= '0;
            r_cells   <= ca5fpc_pkg::CELLS_RESET;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ca5fpc_pkg::CFG_IDX_RULE:  r_rule  <= i_cfg_data;
                    ca5fpc_pkg::CFG_IDX_CELLS: r_cells <= i_cfg_data[ca5fpc_pkg::CELLS_W-1:0];
                    default: begin
                        r_rule <= r_rule;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask    <= n_mask;
        r_addr    <= n_addr;
        r_start   <= n_start;
        r_cur     <= n_cur;
        r_nxt     <= n_nxt;
        r_count   <= n_count;
        r_multi   <= n_multi;
        r_m_multi <= n_m_multi;
        r_m_count <= n_m_count;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_count, r_m_multi};

endmodule

### rtl/ca5fpc_checker.sv
// Port checker for the automaton cycle checker, attached to the top level by bind.
// Depends on ca5fpc_pkg and ca5_fixed_point_cycle_checker_core.
`timescale 1ns / 1ps

module ca5fpc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [ca5fpc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ca5fpc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // A go word starts a run, so the input is busy on the next cycle.
    a_busy_after_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=> !s_axis_tready)
        else $error("input ready right after a go word");

    // A new result only appears at the end of a run.
    a_result_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result word appeared without a run");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

endmodule

bind ca5_fixed_point_cycle_checker_core ca5fpc_checker u_ca5fpc_checker (.*);

### tb/ca5_fixed_point_cycle_checker_core_tb.sv
// Testbench for ca5_fixed_point_cycle_checker_core: directed table, then random phases.
// Depends on ca5fpc_pkg and the core; results are checked against table verdicts or an in-bench predictor.
`timescale 1ns / 1ps

module ca5_fixed_point_cycle_checker_core_tb;

    localparam int MAX_CELLS  = 12;
    localparam int STORE_SIZE = 1 << MAX_CELLS;
    localparam int N_DIR      = 21;
    localparam int N_PHASES   = 10;
    localparam int PHASE_GOS  = 7;
    localparam int HOLD_OFF   = 2000;

    typedef struct packed {
        logic               multi;
        ca5fpc_pkg::t_count count;
    } t_verdict;

    typedef struct packed {
        logic                          wr;
        logic [ca5fpc_pkg::RULE_W-1:0] rule;
        logic [3:0]                    cells;
        logic                          go;
        logic                          typed;
        logic                          multi;
        ca5fpc_pkg::t_count            count;
    } t_dir_row;

    // Rows with typed set carry a verdict that follows directly from the rule.
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{1'b0, 32'h0000_0000, 4'd0,  1'b1, 1'b1, 1'b0, 13'd1},
        '{1'b0, 32'h0000_0000, 4'd0,  1'b0, 1'b0, 1'b0, 13'd0},
        '{1'b1, 32'hF0F0_F0F0, 4'd12, 1'b1, 1'b1, 1'b0, 13'd4096},
        '{1'b1, 32'h0F0F_0F0F, 4'd12, 1'b1, 1'b1, 1'b1, 13'd0},
        '{1'b1, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1, 1'b0, 13'd1},
        '{1'b1, 32'h0000_0000, 4'd13, 1'b1, 1'b1, 1'b0, 13'd1},
        '{1'b1, 32'h0F0F_0F0F, 4'd14, 1'b1, 1'b1, 1'b1, 13'd0},
        '{1'b1, 32'hF0F0_F0F0, 4'd0,  1'b1, 1'b1, 1'b0, 13'd2},
        '{1'b1, 32'h0F0F_0F0F, 4'd1,  1'b1, 1'b1, 1'b1, 13'd0},
        '{1'b1, 32'hF0F0_F0F0, 4'd11, 1'b1, 1'b1, 1'b0, 13'd2048},
        '{1'b1, 32'hF0F0_F0F0, 4'd5,  1'b1, 1'b1, 1'b0, 13'd32},
        '{1'b1, 32'hAAAA_AAAA, 4'd7,  1'b1, 1'b0, 1'b0, 13'd0},
        '{1'b1, 32'hCCCC_CCCC, 4'd6,  1'b1, 1'b0, 1'b0, 13'd0},
        '{1'b1, 32'hFF00_FF00, 4'd6,  1'b1, 1'b0, 1'b0, 13'd0},
        '{1'b1, 32'h9669_6996, 4'd4,  1'b1, 1'b0, 1'b0, 13'd0},
        '{1'b0, 32'h0000_0000, 4'd0,  1'b1, 1'b0, 1'b0, 13'd0},
        '{1'b0, 32'h0000_0000, 4'd0,  1'b0, 1'b0, 1'b0, 13'd0},
        '{1'b1, 32'h0000_0001, 4'd2,  1'b1, 1'b0, 1'b0, 13'd0},
        '{1'b1, 32'h8000_0000, 4'd3,  1'b1, 1'b0, 1'b0, 13'd0},
        '{1'b1, 32'h1E1E_1E1E, 4'd5,  1'b1, 1'b0, 1'b0, 13'd0},
        '{1'b1, 32'h5A5A_5A5A, 4'd6,  1'b1, 1'b0, 1'b0, 13'd0}
    };

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_we      = 1'b0;
    logic [ca5fpc_pkg::CFG_IDX_W-1:0] i_cfg_idx     = ca5fpc_pkg::CFG_IDX_RULE;
    logic [ca5fpc_pkg::RULE_W-1:0]    i_cfg_data    = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ca5fpc_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;    // go, zero fill
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [ca5fpc_pkg::M_TDATA_W-1:0] m_axis_tdata;          // multi, count, zero fill

    logic [ca5fpc_pkg::RULE_W-1:0]    rule_shadow  = '0;
    logic [ca5fpc_pkg::CELLS_W-1:0]   cells_shadow = ca5fpc_pkg::CELLS_RESET;
    int unsigned                      walk_tag [STORE_SIZE];
    bit                               fixed_seen [STORE_SIZE];
    t_verdict                         pending_verdicts [$];
    int                               err_count    = 0;
    bit                               idle_en      = 1'b1;
    bit                               gaps_en      = 1'b1;
    bit                               hold_off_req = 1'b0;

    ca5_fixed_point_cycle_checker_core #(.MAX_CELLS(MAX_CELLS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [MAX_CELLS-1:0] ca_next_state(
        input logic [MAX_CELLS-1:0]          cur,
        input int                            n,
        input logic [ca5fpc_pkg::RULE_W-1:0] rule
    );
        logic [MAX_CELLS+3:0]              wide;
        logic [MAX_CELLS-1:0]              nx;
        logic [ca5fpc_pkg::WINDOW_W-1:0]   code;
        wide = '0;
        nx   = '0;
        for (int b = 0; b < n; b++) begin
            wide[b+2] = cur[b];
        end
        for (int b = 0; b < n; b++) begin
            code  = wide[b +: ca5fpc_pkg::WINDOW_W];
            nx[b] = rule[code];
        end
        return nx;
    endfunction

    function automatic t_verdict analyze_cycles(
        input logic [ca5fpc_pkg::RULE_W-1:0]  rule,
        input logic [ca5fpc_pkg::CELLS_W-1:0] cells
    );
        t_verdict             v;
        int                   n;
        int                   states;
        int unsigned          tag;
        logic [MAX_CELLS-1:0] cur;
        logic [MAX_CELLS-1:0] nxt;
        n = cells;
        if (n < 1) begin
            n = 1;
        end
        if (n > MAX_CELLS) begin
            n = MAX_CELLS;
        end
        states = 1 << n;
        for (int i = 0; i < STORE_SIZE; i++) begin
            walk_tag[i]   = 0;
            fixed_seen[i] = 1'b0;
        end
        v = '0;
        for (int s = 0; s < states && !v.multi; s++) begin
            tag           = s + 1;
            cur           = s[MAX_CELLS-1:0];
            walk_tag[cur] = tag;
            nxt           = ca_next_state(cur, n, rule);
            for (int j = 0; j < states; j++) begin
                if (walk_tag[nxt] != tag) begin
                    walk_tag[nxt] = tag;
                end else if (cur == nxt) begin
                    if (!fixed_seen[nxt]) begin
                        fixed_seen[nxt] = 1'b1;
                        v.count         = v.count + 1'b1;
                    end
                    break;
                end else begin
                    v.multi = 1'b1;
                    break;
                end
                cur = nxt;
                nxt = ca_next_state(cur, n, rule);
            end
        end
        return v;
    endfunction

    task automatic send_word(input logic go, input logic typed, input t_verdict typed_v);
        s_axis_tdata  <= ca5fpc_pkg::S_TDATA_W'(go);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (go) begin
            if (typed) begin
                pending_verdicts.push_back(typed_v);
            end else begin
                pending_verdicts.push_back(analyze_cycles(rule_shadow, cells_shadow));
            end
        end
        if (gaps_en && idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(
        input logic [ca5fpc_pkg::RULE_W-1:0] rule,
        input logic [ca5fpc_pkg::RULE_W-1:0] cells_word
    );
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ca5fpc_pkg::CFG_IDX_RULE;
        i_cfg_data <= rule;
        @(posedge i_clk);
        i_cfg_idx  <= ca5fpc_pkg::CFG_IDX_CELLS;
        i_cfg_data <= cells_word;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        rule_shadow  = rule;
        cells_shadow = cells_word[ca5fpc_pkg::CELLS_W-1:0];
    endtask

    initial begin : sink
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result word with no expectation waiting: %h", m_axis_tdata);
                err_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.multi) begin
                    $error("multi_cycle_found: expected %0d, actual %0d",
                           want.multi, m_axis_tdata[0]);
                    err_count++;
                end
                if (m_axis_tdata[ca5fpc_pkg::COUNT_W:1] !== want.count) begin
                    $error("fixed_point_count: expected %0d, actual %0d",
                           want.count, m_axis_tdata[ca5fpc_pkg::COUNT_W:1]);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row                      row;
        logic [ca5fpc_pkg::RULE_W-1:0] rnd_rule;
        logic [ca5fpc_pkg::RULE_W-1:0] cells_word;
        int                            gos;
        logic                          go;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            row = DIR_ROWS[i];
            if (row.wr) begin
                wait_idle();
                load_config(row.rule, ca5fpc_pkg::RULE_W'(row.cells));
            end
            send_word(row.go, row.typed, '{row.multi, row.count});
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_idle();
            idle_en = (phase < N_PHASES - 2);
            if ($urandom_range(0, 3) == 0) begin
                rnd_rule = {4{8'($urandom())}};
            end else begin
                rnd_rule = $urandom();
            end
            if (phase == 2) begin
                cells_word = 32'd3;
            end else if ($urandom_range(0, 9) == 0) begin
                cells_word = 32'd6;
            end else begin
                cells_word = ca5fpc_pkg::RULE_W'($urandom_range(0, 5));
            end
            if ($urandom_range(0, 1) == 0) begin
                cells_word = ($urandom() & 32'hFFFF_FFF0) | cells_word;
            end
            load_config(rnd_rule, cells_word);
            gaps_en = (phase != 2);
            if (phase == 2) begin
                hold_off_req = 1'b1;
            end
            gos = 0;
            while (gos < PHASE_GOS) begin
                go = ($urandom_range(0, 6) != 0);
                send_word(go, 1'b0, '0);
                if (go) begin
                    gos++;
                end
            end
            gaps_en = 1'b1;
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ca5_fixed_point_cycle_checker_core_tb passed");
        end else begin
            $display("ca5_fixed_point_cycle_checker_core_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("ca5_fixed_point_cycle_checker_core_tb failed");
        $finish;
    end

endmodule
